@@ sv/mtbc_pkg.sv @@
// Shared types and constants of the median temperature band classifier.
`default_nettype none

package mtbc_pkg;

  localparam int LimitW  = 10;
  localparam int MedianW = 10;
  localparam int BandW   = 3;
  localparam int CfgIdxW = 2;

  typedef enum logic [BandW-1:0] {
    BAND_UNKNOWN = 3'd0,
    BAND_COLD    = 3'd1,
    BAND_NORMAL  = 3'd2,
    BAND_WARM    = 3'd3,
    BAND_HOT     = 3'd4
  } band_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLD   = 2'd0,
    CFG_NORMAL = 2'd1,
    CFG_WARM   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  localparam logic [LimitW-1:0] ColdLimitRst   = 10'd140;
  localparam logic [LimitW-1:0] NormalLimitRst = 10'd152;
  localparam logic [LimitW-1:0] WarmLimitRst   = 10'd156;

endpackage

`default_nettype wire

@@ sv/mtbc_if.sv @@
// Handshake channels of the classifier: the sample input and the result output.
`default_nettype none

interface mtbc_smp_if #(
  parameter int SampleBits = 10
);
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mtbc_res_if;
  import mtbc_pkg::*;

  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [MedianW-1:0] median_sample;
  logic [BandW-1:0]   band;
  logic               changed;
  logic               first_change;

  modport source (output valid, output valid_res, output median_sample, output band,
                  output changed, output first_change, input ready);
  modport sink   (input valid, input valid_res, input median_sample, input band,
                  input changed, input first_change, output ready);
endinterface

`default_nettype wire

@@ sv/median_temperature_band_classifier.sv @@
// Top level of the median temperature band classifier.
`default_nettype none

// Each sample beat is written into a ring of the last WINDOW samples, held in
// two identical RAMs with one write port and one read port each. Until WINDOW
// samples have arrived the result beat has valid_res low, a zero median, the
// stored band and no change flags. Once the window is full the median is
// found by rank counting: every stored sample in turn is the candidate, read
// from one RAM copy, while the other copy is swept over the whole window and
// the samples that rank below the candidate are counted (equal values are
// ordered by slot, so the ranks are distinct). The candidate whose rank is
// WINDOW/2 is the median, the upper middle one for an even window. The sweep
// of the second RAM, one read per cycle, sets how long a full-window beat
// takes, less when the median turns up early. The median is then classed by
// the three inclusive raw-code limits, tested cold, normal, warm in that
// order, anything above all three limits being hot. The stored band starts
// unknown; changed flags a beat whose band differs from it and first_change
// flags the change out of unknown. A finished result waits in an output
// register, so the next sample beat is taken while it is still pending. The
// limits are written through the plain write port; the user must write them
// only while no beat is in work, which the block does not enforce. Indexes
// beyond the warm limit are ignored.
module median_temperature_band_classifier #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  mtbc_smp_if.sink                      smp_i,
  mtbc_res_if.source                    res_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [mtbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [mtbc_pkg::LimitW-1:0]  cfg_data_i
);

  import mtbc_pkg::*;

  localparam int IdxW  = $clog2(WINDOW);
  localparam int FillW = $clog2(WINDOW + 1);
  // Common width for comparing the median with the limits and for the output.
  localparam int ExtW  = (SAMPLE_BITS > LimitW) ? SAMPLE_BITS : LimitW;

  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(WINDOW - 1);
  localparam logic [IdxW-1:0]  HalfRank = IdxW'(WINDOW / 2);
  localparam logic [FillW-1:0] FillFull = FillW'(WINDOW);

  // Configuration limits.
  logic [LimitW-1:0] cold_lim_q, normal_lim_q, warm_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cold_lim_q   <= ColdLimitRst;
      normal_lim_q <= NormalLimitRst;
      warm_lim_q   <= WarmLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLD:   cold_lim_q   <= cfg_data_i;
        CFG_NORMAL: normal_lim_q <= cfg_data_i;
        CFG_WARM:   warm_lim_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Control state and datapath registers.
  state_e                 state_q, state_d;
  logic [IdxW-1:0]        wslot_q, wslot_d;
  logic [FillW-1:0]       fill_q, fill_d;
  band_e                  band_q, band_d;
  logic [IdxW-1:0]        cand_q, cand_d;      // candidate slot being issued
  logic [IdxW-1:0]        sweep_q, sweep_d;    // comparison slot being issued
  logic                   issue_done_q, issue_done_d;
  logic                   rd_vld_q, rd_vld_d;  // read data arrives this cycle
  logic [IdxW-1:0]        rd_cand_q, rd_sweep_q;
  logic [IdxW-1:0]        rank_q, rank_d;
  logic [SAMPLE_BITS-1:0] med_q, med_d;
  logic                   med_ok_q, med_ok_d;

  // Output register.
  logic               res_vld_q, res_vld_d;
  logic               res_valid_res_q, res_valid_res_d;
  logic [MedianW-1:0] res_med_q, res_med_d;
  band_e              res_band_q, res_band_d;
  logic               res_chg_q, res_chg_d;
  logic               res_first_q, res_first_d;

  // RAM ports.
  logic                   ram_we;
  logic [IdxW-1:0]        ram_raddr_a, ram_raddr_b;
  logic [SAMPLE_BITS-1:0] cand_rdata, sweep_rdata;

  mtbc_ram #(.Width(SAMPLE_BITS), .Depth(WINDOW)) u_ram_cand (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot_q),
    .wdata_i (smp_i.sample),
    .raddr_i (ram_raddr_a),
    .rdata_o (cand_rdata)
  );

  mtbc_ram #(.Width(SAMPLE_BITS), .Depth(WINDOW)) u_ram_sweep (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot_q),
    .wdata_i (smp_i.sample),
    .raddr_i (ram_raddr_b),
    .rdata_o (sweep_rdata)
  );

  // Rank contribution of the sweep sample against the candidate; ties are
  // broken by slot so that every sample has a distinct rank.
  logic            below;
  logic [IdxW-1:0] rank_new;
  assign below = (sweep_rdata < cand_rdata) ||
                 ((sweep_rdata == cand_rdata) && (rd_sweep_q < rd_cand_q));
  assign rank_new = ((rd_sweep_q == '0) ? '0 : rank_q) + IdxW'(below);

  // Classification of the median found.
  logic [ExtW-1:0] med_ext;
  band_e           new_band;
  assign med_ext = ExtW'(med_q);

  always_comb begin
    if (med_ext <= ExtW'(cold_lim_q)) begin
      new_band = BAND_COLD;
    end else if (med_ext <= ExtW'(normal_lim_q)) begin
      new_band = BAND_NORMAL;
    end else if (med_ext <= ExtW'(warm_lim_q)) begin
      new_band = BAND_WARM;
    end else begin
      new_band = BAND_HOT;
    end
  end

  logic out_free;
  assign out_free = !res_vld_q || res_o.ready;

  always_comb begin
    state_d         = state_q;
    wslot_d         = wslot_q;
    fill_d          = fill_q;
    band_d          = band_q;
    cand_d          = cand_q;
    sweep_d         = sweep_q;
    issue_done_d    = issue_done_q;
    rd_vld_d        = 1'b0;
    rank_d          = rank_q;
    med_d           = med_q;
    med_ok_d        = med_ok_q;
    res_vld_d       = res_vld_q && !res_o.ready;
    res_valid_res_d = res_valid_res_q;
    res_med_d       = res_med_q;
    res_band_d      = res_band_q;
    res_chg_d       = res_chg_q;
    res_first_d     = res_first_q;
    ram_we          = 1'b0;
    ram_raddr_a     = cand_q;
    ram_raddr_b     = sweep_q;
    smp_i.ready     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        smp_i.ready = 1'b1;
        if (smp_i.valid) begin
          ram_we       = 1'b1;
          wslot_d      = (wslot_q == LastIdx) ? '0 : wslot_q + 1'b1;
          fill_d       = (fill_q == FillFull) ? fill_q : fill_q + 1'b1;
          cand_d       = '0;
          sweep_d      = '0;
          issue_done_d = 1'b0;
          med_ok_d     = 1'b0;
          state_d      = (fill_d == FillFull) ? ST_SCAN : ST_EMIT;
        end
      end

      ST_SCAN: begin
        if (!issue_done_q) begin
          rd_vld_d = 1'b1;
          if (sweep_q == LastIdx) begin
            sweep_d = '0;
            if (cand_q == LastIdx) begin
              issue_done_d = 1'b1;
            end else begin
              cand_d = cand_q + 1'b1;
            end
          end else begin
            sweep_d = sweep_q + 1'b1;
          end
        end
        if (rd_vld_q) begin
          rank_d = rank_new;
          if ((rd_sweep_q == LastIdx) && (rank_new == HalfRank)) begin
            med_d    = cand_rdata;
            med_ok_d = 1'b1;
            rd_vld_d = 1'b0;
            state_d  = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          res_vld_d = 1'b1;
          if (med_ok_q) begin
            res_valid_res_d = 1'b1;
            res_med_d       = med_ext[MedianW-1:0];
            res_band_d      = new_band;
            res_chg_d       = (new_band != band_q);
            res_first_d     = (new_band != band_q) && (band_q == BAND_UNKNOWN);
            band_d          = new_band;
          end else begin
            res_valid_res_d = 1'b0;
            res_med_d       = '0;
            res_band_d      = band_q;
            res_chg_d       = 1'b0;
            res_first_d     = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wslot_q      <= '0;
      fill_q       <= '0;
      band_q       <= BAND_UNKNOWN;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      wslot_q      <= wslot_d;
      fill_q       <= fill_d;
      band_q       <= band_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      res_vld_q    <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q          <= cand_d;
    sweep_q         <= sweep_d;
    rd_cand_q       <= cand_q;
    rd_sweep_q      <= sweep_q;
    rank_q          <= rank_d;
    med_q           <= med_d;
    med_ok_q        <= med_ok_d;
    res_valid_res_q <= res_valid_res_d;
    res_med_q       <= res_med_d;
    res_band_q      <= res_band_d;
    res_chg_q       <= res_chg_d;
    res_first_q     <= res_first_d;
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.valid_res     = res_valid_res_q;
  assign res_o.median_sample = res_med_q;
  assign res_o.band          = res_band_q;
  assign res_o.changed       = res_chg_q;
  assign res_o.first_change  = res_first_q;

endmodule

`default_nettype wire

@@ sv/mtbc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mtbc_ram #(
  parameter int Width = 10,
  parameter int Depth = 5
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ verif/tb_median_temperature_band_classifier.sv @@
// Self-checking testbench of the median temperature band classifier.
module tb_median_temperature_band_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import mtbc_pkg::*;

  localparam int Window     = 5;
  localparam int SampleBits = 10;
  localparam int SampleMax  = (1 << SampleBits) - 1;

  // The directed rows are followed by seven random phases, each under its own
  // set of band limits, for about 1150 sample beats in all.
  localparam int DirRows    = 23;
  localparam int RandPhases = 7;
  localparam int PhaseBeats = 161;

  // Once this many result beats have arrived, the receiver stalls for a long
  // stretch so that the block fills up and holds off new samples.
  localparam int HoldAfter  = 300;
  localparam int HoldCycles = 400;

  // After the drain, which gives up at DrainLimit, a final settle follows
  // before the verdict is printed.
  localparam int DrainLimit   = 20000;
  localparam int SettleCycles = 64;

  typedef struct packed {
    logic                valid_res;
    logic [MedianW-1:0]  median_sample;
    band_e               band;
    logic                changed;
    logic                first_change;
  } beat_t;

  // One directed stimulus row. When typed is set, the row carries its own
  // expected result; otherwise the predictor supplies it.
  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  typed;
    beat_t                 want;
  } dir_row_t;

  localparam beat_t NotFull = '{1'b0, '0, BAND_UNKNOWN, 1'b0, 1'b0};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [LimitW-1:0]   cfg_data;

  mtbc_smp_if #(.SampleBits(SampleBits)) smp_if ();
  mtbc_res_if                            res_if ();

  median_temperature_band_classifier #(
    .WINDOW      (Window),
    .SAMPLE_BITS (SampleBits)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .smp_i      (smp_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: the sample ring, its fill level, the stored band and
  // the three band limits as last written.
  logic [SampleBits-1:0] ring [Window];
  int                    ring_slot;
  int                    ring_fill;
  band_e                 held_band;
  logic [LimitW-1:0]     cold_lim;
  logic [LimitW-1:0]     normal_lim;
  logic [LimitW-1:0]     warm_lim;

  beat_t expected_beats [$];
  int    mismatches;
  int    beats_seen;
  int    src_gap_pct;
  int    sink_stall_pct;
  int    last_pick;

  // Directed part. The first rows fill the window with full-scale codes: four
  // beats with no median yet, then a hot median that leaves the unknown band.
  // Zeros then push the median down to cold once three of them sit in the
  // window. The remaining rows walk the default limits and the codes just
  // above them, in short runs so that the median lands on each boundary.
  dir_row_t dir_rows [DirRows] = '{
    '{10'd1023, 1'b1, NotFull},
    '{10'd1023, 1'b1, NotFull},
    '{10'd1023, 1'b1, NotFull},
    '{10'd1023, 1'b1, NotFull},
    '{10'd1023, 1'b1, '{1'b1, 10'd1023, BAND_HOT, 1'b1, 1'b1}},
    '{10'd0,    1'b1, '{1'b1, 10'd1023, BAND_HOT, 1'b0, 1'b0}},
    '{10'd0,    1'b1, '{1'b1, 10'd1023, BAND_HOT, 1'b0, 1'b0}},
    '{10'd0,    1'b1, '{1'b1, 10'd0,    BAND_COLD, 1'b1, 1'b0}},
    '{10'd140,  1'b0, NotFull},
    '{10'd140,  1'b0, NotFull},
    '{10'd141,  1'b0, NotFull},
    '{10'd141,  1'b0, NotFull},
    '{10'd141,  1'b0, NotFull},
    '{10'd152,  1'b0, NotFull},
    '{10'd152,  1'b0, NotFull},
    '{10'd153,  1'b0, NotFull},
    '{10'd153,  1'b0, NotFull},
    '{10'd153,  1'b0, NotFull},
    '{10'd156,  1'b0, NotFull},
    '{10'd156,  1'b0, NotFull},
    '{10'd157,  1'b0, NotFull},
    '{10'd157,  1'b0, NotFull},
    '{10'd157,  1'b0, NotFull}
  };

  // Band limits of the random phases. The first phase rewrites the reset
  // values, then come all-zero and all-full limits, limits out of order (so
  // the normal band can never occur), a split that leaves no room for hot,
  // and two random settings. A negative entry means a random limit.
  int phase_cold   [RandPhases] = '{140, 0,    1023, 600, -1, 0,    -1};
  int phase_normal [RandPhases] = '{152, 0,    1023, 300, -1, 512,  -1};
  int phase_warm   [RandPhases] = '{156, 0,    1023, 900, -1, 1023, -1};
  // Idle rates per phase, in percent; the last phase runs with no idling.
  int phase_gap    [RandPhases] = '{10, 30, 5, 50, 20, 15, 0};
  int phase_stall  [RandPhases] = '{10, 5, 40, 50, 20, 15, 0};

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Median by rank: a stored code is the median when at most WINDOW/2 codes
  // lie strictly below it and more than WINDOW/2 lie at or below it. For an
  // odd window this picks the exact middle element.
  function automatic logic [SampleBits-1:0] window_median();
    int below;
    int at_or_below;
    for (int i = 0; i < Window; i++) begin
      below       = 0;
      at_or_below = 0;
      for (int j = 0; j < Window; j++) begin
        if (ring[j] < ring[i]) below++;
        if (ring[j] <= ring[i]) at_or_below++;
      end
      if (below <= Window / 2 && at_or_below > Window / 2) return ring[i];
    end
    return '0;
  endfunction

  // Limits are inclusive upper bounds, tested cold first and warm last, so
  // when they are out of order the first match wins.
  function automatic band_e band_of(input logic [MedianW-1:0] median);
    if (median <= cold_lim) return BAND_COLD;
    if (median <= normal_lim) return BAND_NORMAL;
    if (median <= warm_lim) return BAND_WARM;
    return BAND_HOT;
  endfunction

  // Advances the predictor by one accepted sample and returns the result
  // beat that the sample must cause.
  function automatic beat_t predict_beat(input logic [SampleBits-1:0] sample);
    beat_t r;
    band_e next_band;
    ring[ring_slot] = sample;
    ring_slot = (ring_slot == Window - 1) ? 0 : ring_slot + 1;
    if (ring_fill < Window) ring_fill++;
    r = NotFull;
    if (ring_fill < Window) begin
      // Window not yet full: no median, the stored band and no change flags.
      r.band = held_band;
    end else begin
      r.valid_res     = 1'b1;
      r.median_sample = window_median();
      next_band       = band_of(r.median_sample);
      r.band          = next_band;
      r.changed       = (next_band != held_band);
      r.first_change  = r.changed && (held_band == BAND_UNKNOWN);
      held_band       = next_band;
    end
    return r;
  endfunction

  // Random samples: some full-range codes so that every bit toggles, long
  // runs of one code so that the median settles, and, half the time, codes
  // close to one of the current limits so that the band keeps moving.
  function automatic logic [SampleBits-1:0] pick_sample();
    int v;
    int base;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom_range(0, SampleMax);
      2, 3: v = last_pick;
      default: begin
        case ($urandom_range(0, 2))
          0:       base = int'(cold_lim);
          1:       base = int'(normal_lim);
          default: base = int'(warm_lim);
        endcase
        v = base + int'($urandom_range(0, 16)) - 8;
      end
    endcase
    if (v < 0) v = 0;
    if (v > SampleMax) v = SampleMax;
    last_pick = v;
    return v[SampleBits-1:0];
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s mismatch on result beat %0d: expected %0d, got %0d",
               $realtime, field, beats_seen, want, got);
    end
  endfunction

  // Compares one accepted result beat with the oldest expectation.
  task automatic check_beat();
    beat_t want;
    beat_t got;
    got.valid_res     = res_if.valid_res;
    got.median_sample = res_if.median_sample;
    got.band          = band_e'(res_if.band);
    got.changed       = res_if.changed;
    got.first_change  = res_if.first_change;
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] result beat %0d arrived with nothing expected", $realtime, beats_seen);
      end
    end else begin
      want = expected_beats.pop_front();
      if (got.valid_res !== want.valid_res)
        note_mismatch("valid_res", 32'(want.valid_res), 32'(got.valid_res));
      if (got.median_sample !== want.median_sample)
        note_mismatch("median_sample", 32'(want.median_sample), 32'(got.median_sample));
      if (got.band !== want.band)
        note_mismatch("band", 32'(want.band), 32'(got.band));
      if (got.changed !== want.changed)
        note_mismatch("changed", 32'(want.changed), 32'(got.changed));
      if (got.first_change !== want.first_change)
        note_mismatch("first_change", 32'(want.first_change), 32'(got.first_change));
    end
    beats_seen++;
  endtask

  // Offers one sample beat, after an optional idle burst, and waits until
  // the block takes it. The expectation is queued at the accepting edge; a
  // typed row supplies its own, but the predictor still steps so that its
  // state follows the block. Returns at the falling edge with valid still
  // high, so back-to-back beats need no gap.
  task automatic send_sample(input logic [SampleBits-1:0] sample, input logic typed,
                             input beat_t want);
    beat_t predicted;
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      smp_if.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    smp_if.valid  = 1'b1;
    smp_if.sample = sample;
    do @(posedge clk); while (!smp_if.ready);
    predicted = predict_beat(sample);
    expected_beats.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Writes all three limits, one per cycle, and mirrors them in the predictor.
  task automatic write_limits(input logic [LimitW-1:0] cold, input logic [LimitW-1:0] normal,
                              input logic [LimitW-1:0] warm);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = CFG_COLD;
    cfg_data = cold;
    cold_lim = cold;
    @(negedge clk);
    cfg_idx    = CFG_NORMAL;
    cfg_data   = normal;
    normal_lim = normal;
    @(negedge clk);
    cfg_idx  = CFG_WARM;
    cfg_data = warm;
    warm_lim = warm;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stimulus: reset, the directed rows under the reset limits, then the
  // random phases. Limits change only once every expected beat has arrived,
  // since every sample causes exactly one result and the block is then idle.
  initial begin
    int waited;
    logic [LimitW-1:0] lim_a;
    logic [LimitW-1:0] lim_b;
    logic [LimitW-1:0] lim_c;

    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_COLD;
    cfg_data      = '0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    for (int i = 0; i < Window; i++) ring[i] = '0;
    ring_slot      = 0;
    ring_fill      = 0;
    held_band      = BAND_UNKNOWN;
    cold_lim       = ColdLimitRst;
    normal_lim     = NormalLimitRst;
    warm_lim       = WarmLimitRst;
    mismatches     = 0;
    beats_seen     = 0;
    last_pick      = 0;
    src_gap_pct    = 20;
    sink_stall_pct = 20;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DirRows; r++) begin
      send_sample(dir_rows[r].sample, dir_rows[r].typed, dir_rows[r].want);
    end

    for (int p = 0; p < RandPhases; p++) begin
      smp_if.valid = 1'b0;
      while (expected_beats.size() != 0) @(posedge clk);
      // A random setting is drawn in order, except in the last phase, where
      // it may come out of order as well.
      lim_a = (phase_cold[p] >= 0) ? LimitW'(phase_cold[p]) :
                                     LimitW'($urandom_range(0, SampleMax));
      if (phase_normal[p] >= 0) begin
        lim_b = LimitW'(phase_normal[p]);
        lim_c = LimitW'(phase_warm[p]);
      end else if (p == RandPhases - 1) begin
        lim_b = LimitW'($urandom_range(0, SampleMax));
        lim_c = LimitW'($urandom_range(0, SampleMax));
      end else begin
        lim_b = LimitW'($urandom_range(lim_a, SampleMax));
        lim_c = LimitW'($urandom_range(lim_b, SampleMax));
      end
      write_limits(lim_a, lim_b, lim_c);
      src_gap_pct    = phase_gap[p];
      sink_stall_pct = phase_stall[p];
      for (int n = 0; n < PhaseBeats; n++) begin
        send_sample(pick_sample(), 1'b0, NotFull);
      end
    end
    smp_if.valid = 1'b0;

    waited = 0;
    while (expected_beats.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_beats.size() != 0) begin
      $display("%0d expected result beats never arrived", expected_beats.size());
      mismatches += expected_beats.size();
    end
    repeat (SettleCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random stall bursts, and one long hold-off after HoldAfter
  // result beats so that the output register and the block back up.
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && beats_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready = 1'b0;
      end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left   = $urandom_range(1, 14) - 1;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // Result monitor: every beat taken at a rising edge is checked.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) check_beat();
    end
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
sv/mtbc_pkg.sv
sv/mtbc_if.sv
sv/mtbc_ram.sv
sv/median_temperature_band_classifier.sv
verif/tb_median_temperature_band_classifier.sv
